/* design/omcc_pkg.sv */
// ----------------------------------------------------------------------------
// omcc_pkg
// types and constants for the osc message classifier
// ----------------------------------------------------------------------------
`default_nettype none
package omcc_pkg;
   localparam logic [2:0] PH_ADDR = 3'd0;
   localparam logic [2:0] PH_PAD1 = 3'd1;
   localparam logic [2:0] PH_TAG  = 3'd2;
   localparam logic [2:0] PH_PAD2 = 3'd3;
   localparam logic [2:0] PH_ARG  = 3'd4;
   localparam logic [2:0] PH_IDLE = 3'd5;

   localparam logic [3:0] RSN_OK       = 4'd0;
   localparam logic [3:0] RSN_NO_SLASH = 4'd1;
   localparam logic [3:0] RSN_NO_TERM  = 4'd2;
   localparam logic [3:0] RSN_NO_RULE  = 4'd3;
   localparam logic [3:0] RSN_DIGIT    = 4'd4;
   localparam logic [3:0] RSN_NO_COMMA = 4'd5;
   localparam logic [3:0] RSN_NOT_INT  = 4'd6;
   localparam logic [3:0] RSN_TAG_OPEN = 4'd7;
   localparam logic [3:0] RSN_ARG_SHORT = 4'd8;
   localparam logic [3:0] RSN_BAD_UTF8 = 4'd9;
   localparam logic [3:0] RSN_OVERSIZE = 4'd10;

   localparam logic [2:0] CSR_ATTR   = 3'd6;
   localparam logic [2:0] CSR_BYPASS = 3'd7;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [31:0] channel_id;
      logic [9:0]  address_length;
      logic        keyed_by_channel;
      logic [1:0]  rule_index;
      logic [3:0]  reject_reason;
      logic        accepted;
   } verdict_type;
endpackage
`default_nettype wire

/* design/osc_message_coalesce_classifier_top.sv */
// ----------------------------------------------------------------------------
// osc_message_coalesce_classifier_top
// byte-serial osc packet classifier, one verdict per packet
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   req_     in   tdata packet_byte, tlast end_of_packet
//   rsp_     out  tdata verdict fields
//   csr_     in   register write port
// one byte per cycle while req_tready is high; the parser state updates in
// the cycle a byte is taken. the verdict is registered in the rsp output
// stage when the last byte is taken and holds under stall.
// req_tready drops while a verdict waits and rsp_tready is low.
// reset is synchronous and clears parser state, registers and the output valid flag.
`default_nettype none
module osc_message_coalesce_classifier_top
   import omcc_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 1024,
   parameter int NUM_RULES        = 3,
   parameter int MAX_PREFIX_BYTES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // packet_byte
   input  wire         req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // accepted, reject_reason[4], rule_index[2],
                                    // keyed_by_channel, address_length[10],
                                    // channel_id[32], 6 zero bits
   input  wire         csr_wen,
   input  wire  [2:0]  csr_index,
   input  wire  [63:0] csr_wdata
);
   localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

   logic [63:0] pfx_ff [0:5];
   logic [17:0] attr_ff;
   logic        bypass_ff;

   logic [PW-1:0] pos_ff, pos_in;
   logic [2:0]  ph_ff, ph_in;
   logic [2:0]  match_ff, match_in;
   logic [2:0]  dig_ff, dig_in;
   logic [9:0]  aend_ff, aend_in;
   logic [2:0]  u8_ff, u8_in;
   logic        bad_ff, bad_in;
   logic [2:0]  tag_ff, tag_in;
   logic [31:0] arg_ff, arg_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [3:0]  rsn_ff, rsn_in;
   logic        ov_ff;
   verdict_type out_ff, vd;

   logic take;
   assign req_tready = !ov_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {6'd0, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) pfx_ff[i] <= '0;
         attr_ff <= '0;
         bypass_ff <= 1'b0;
      end else if (csr_wen) begin
         if (csr_index < CSR_ATTR) pfx_ff[csr_index] <= csr_wdata;
         else if (csr_index == CSR_ATTR) attr_ff <= csr_wdata[17:0];
         else if (csr_index == CSR_BYPASS) bypass_ff <= csr_wdata[0];
      end
   end

   function automatic logic [4:0] rlen(input logic [17:0] a, input int r);
      return a[6*r +: 5];
   endfunction

   logic [7:0] b;
   logic [3:0] rsn_fin;
   logic [1:0] sel;
   logic       found;
   logic [4:0] ln;
   logic       u8bad_now;
   assign b = req_tdata;

   always_comb begin
      pos_in = pos_ff; ph_in = ph_ff; match_in = match_ff; dig_in = dig_ff;
      aend_in = aend_ff; u8_in = u8_ff; bad_in = bad_ff; tag_in = tag_ff;
      arg_in = arg_ff; cnt_in = cnt_ff; rsn_in = rsn_ff;
      found = 1'b0; sel = 2'd0; ln = '0; u8bad_now = 1'b0;
      if (pos_ff >= PW'(MAX_PACKET_BYTES)) begin
         rsn_in = RSN_OVERSIZE; ph_in = PH_IDLE;
      end else begin
         pos_in = pos_ff + 1'b1;
         if (rsn_ff == RSN_OK) begin
            case (ph_ff)
               PH_ADDR: begin
                  if (pos_ff == '0 && b != CH_SLASH) begin
                     rsn_in = RSN_NO_SLASH; ph_in = PH_IDLE;
                  end else if (b == 8'd0) begin
                     aend_in = 10'(pos_ff);
                     if (u8_ff != 3'd0) begin
                        bad_in = 1'b1; u8_in = 3'd0;
                     end
                     for (int r = NUM_RULES - 1; r >= 0; r--) begin
                        if (r < 3) begin
                           ln = rlen(attr_ff, r);
                           if (ln != 5'd0 && 32'(ln) <= MAX_PREFIX_BYTES && match_ff[r]
                               && PW'(ln) <= pos_ff) begin
                              found = 1'b1; sel = 2'(r);
                           end
                        end
                     end
                     if (!found) begin
                        rsn_in = RSN_NO_RULE; ph_in = PH_IDLE;
                     end else begin
                        match_in = 3'b001 << sel;
                        if (bypass_ff && attr_ff[6*sel+5] && dig_ff[sel]) begin
                           rsn_in = RSN_DIGIT; ph_in = PH_IDLE;
                        end else if (!attr_ff[6*sel+5]) begin
                           ph_in = PH_IDLE;
                        end else begin
                           tag_in = tag_ff | 3'b100;
                           ph_in = (pos_ff[1:0] == 2'd3) ? PH_TAG : PH_PAD1;
                        end
                     end
                  end else begin
                     for (int r = 0; r < 3; r++) begin
                        if (r < NUM_RULES) begin
                           ln = rlen(attr_ff, r);
                           if (pos_ff < PW'(ln) && 32'(pos_ff) < MAX_PREFIX_BYTES
                               && pos_ff < PW'(16)
                               && pfx_ff[2*r + 32'(pos_ff[3])][8*pos_ff[2:0] +: 8] != b)
                              match_in[r] = 1'b0;
                           if (pos_ff == PW'(ln) && b >= CH_ZERO && b <= CH_NINE)
                              dig_in[r] = 1'b1;
                        end
                     end
                     // utf-8 sequence tracking
                     if (u8_ff != 3'd0) begin
                        case (u8_ff)
                           3'd4: u8bad_now = b < 8'hA0 || b > 8'hBF;
                           3'd5: u8bad_now = b < 8'h80 || b > 8'h9F;
                           3'd6: u8bad_now = b < 8'h90 || b > 8'hBF;
                           3'd7: u8bad_now = b < 8'h80 || b > 8'h8F;
                           default: u8bad_now = b < 8'h80 || b > 8'hBF;
                        endcase
                        if (u8bad_now) begin
                           bad_in = 1'b1; u8_in = 3'd0;
                        end else begin
                           case (u8_ff)
                              3'd3, 3'd6, 3'd7: u8_in = 3'd2;
                              3'd2, 3'd4, 3'd5: u8_in = 3'd1;
                              default: u8_in = 3'd0;
                           endcase
                        end
                     end else if (b >= 8'h80) begin
                        if (b >= 8'hC2 && b <= 8'hDF) u8_in = 3'd1;
                        else if (b == 8'hE0) u8_in = 3'd4;
                        else if (b == 8'hED) u8_in = 3'd5;
                        else if (b >= 8'hE1 && b <= 8'hEF) u8_in = 3'd2;
                        else if (b == 8'hF0) u8_in = 3'd6;
                        else if (b >= 8'hF1 && b <= 8'hF3) u8_in = 3'd3;
                        else if (b == 8'hF4) u8_in = 3'd7;
                        else bad_in = 1'b1;
                     end
                  end
               end
               PH_PAD1: ph_in = (pos_ff[1:0] == 2'd3) ? PH_TAG : PH_PAD1;
               PH_TAG: begin
                  if (!tag_ff[0]) begin
                     if (b != CH_COMMA) begin
                        rsn_in = RSN_NO_COMMA; ph_in = PH_IDLE;
                     end else tag_in[0] = 1'b1;
                  end else if (!tag_ff[1]) begin
                     if (b != CH_I) begin
                        rsn_in = RSN_NOT_INT; ph_in = PH_IDLE;
                     end else tag_in[1] = 1'b1;
                  end else if (b == 8'd0) begin
                     ph_in = (pos_ff[1:0] == 2'd3) ? PH_ARG : PH_PAD2;
                  end
               end
               PH_PAD2: ph_in = (pos_ff[1:0] == 2'd3) ? PH_ARG : PH_PAD2;
               PH_ARG: begin
                  arg_in = {arg_ff[23:0], b};
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff == 3'd3) ph_in = PH_IDLE;
               end
               default: ;
            endcase
         end
      end
      // verdict from the updated state
      if (rsn_in != RSN_OK) rsn_fin = rsn_in;
      else begin
         case (ph_in)
            PH_ADDR: rsn_fin = RSN_NO_TERM;
            PH_PAD1: rsn_fin = RSN_NO_COMMA;
            PH_TAG: rsn_fin = !tag_in[0] ? RSN_NO_COMMA
                            : (!tag_in[1] ? RSN_NOT_INT : RSN_TAG_OPEN);
            PH_PAD2, PH_ARG: rsn_fin = RSN_ARG_SHORT;
            default: rsn_fin = bad_in ? RSN_BAD_UTF8 : RSN_OK;
         endcase
      end
      vd = '0;
      vd.accepted = (rsn_fin == RSN_OK);
      vd.reject_reason = rsn_fin;
      if (rsn_fin == RSN_OK) begin
         vd.rule_index = match_in[0] ? 2'd0 : (match_in[1] ? 2'd1 : 2'd2);
         vd.keyed_by_channel = tag_in[2];
         vd.address_length = aend_in;
         if (tag_in[2]) vd.channel_id = arg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && req_tlast)) begin
         pos_ff <= '0; ph_ff <= PH_ADDR; match_ff <= 3'b111; dig_ff <= '0;
         aend_ff <= '0; u8_ff <= '0; bad_ff <= 1'b0; tag_ff <= '0;
         arg_ff <= '0; cnt_ff <= '0; rsn_ff <= RSN_OK;
      end else if (take) begin
         pos_ff <= pos_in; ph_ff <= ph_in; match_ff <= match_in; dig_ff <= dig_in;
         aend_ff <= aend_in; u8_ff <= u8_in; bad_ff <= bad_in; tag_ff <= tag_in;
         arg_ff <= arg_in; cnt_ff <= cnt_in; rsn_ff <= rsn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (take && req_tlast) ov_ff <= 1'b1;
      else if (rsp_tready) ov_ff <= 1'b0;
      if (take && req_tlast) out_ff <= vd;
   end

   a_acc_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff.accepted == (out_ff.reject_reason == RSN_OK)))
      else $error("accepted disagrees with reason");
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_ff.accepted) |-> (out_ff.channel_id == '0
         && out_ff.address_length == '0))
      else $error("rejected verdict carries fields");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("verdict dropped under stall");
   a_reset_state: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast) |=> (pos_ff == '0 && rsn_ff == RSN_OK))
      else $error("packet state not cleared");
endmodule
`default_nettype wire

/* tb/tb_osc_message_coalesce_classifier_top.sv */
// ----------------------------------------------------------------------------
// tb_osc_message_coalesce_classifier_top
// self-checking bench for the osc message classifier: packets go in byte by
// byte, a verdict model built from the same bytes predicts each result word,
// and every result is compared field by field under random idling on both
// sides, a long output stall and a sweep of rule settings
// ----------------------------------------------------------------------------
`default_nettype none
module tb_osc_message_coalesce_classifier_top;
   import omcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_q_t[$];

   localparam logic [2:0] CSR_PREFIX_BASE = 3'd0;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_BYTES   = 1024;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   osc_message_coalesce_classifier_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mirrored registers
   logic [63:0] prefix_reg [3][2];
   logic [17:0] rule_attr;
   logic        bypass_en;

   // per-packet parser state
   int unsigned pos;
   logic [2:0]  phase;
   logic [2:0]  still_match;
   logic [2:0]  digit_seen;
   int unsigned addr_end;
   logic [2:0]  utf8_state;
   bit          utf8_bad;
   logic [2:0]  tag_bits;
   logic [31:0] arg_shift;
   int unsigned arg_count;
   logic [3:0]  latched_reason;

   verdict_type verdict_q[$];
   int unsigned bytes_taken = 0;
   int unsigned packets_sent = 0;
   int unsigned verdicts_seen = 0;
   int unsigned accepts_seen = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   int unsigned hold_cycles = 0;

   function automatic void clear_packet_state();
      pos = 0;
      phase = PH_ADDR;
      still_match = 3'b111;
      digit_seen = '0;
      addr_end = 0;
      utf8_state = '0;
      utf8_bad = 0;
      tag_bits = '0;
      arg_shift = '0;
      arg_count = 0;
      latched_reason = RSN_OK;
   endfunction

   function automatic void set_reject(logic [3:0] why);
      latched_reason = why;
      phase = PH_IDLE;
   endfunction

   function automatic void step_utf8(logic [7:0] b);
      logic [7:0] lo_lim;
      logic [7:0] hi_lim;
      if (utf8_state != 0) begin
         lo_lim = (utf8_state == 4) ? 8'hA0 : (utf8_state == 6) ? 8'h90 : 8'h80;
         hi_lim = (utf8_state == 5) ? 8'h9F : (utf8_state == 7) ? 8'h8F : 8'hBF;
         if (b < lo_lim || b > hi_lim) begin
            utf8_bad = 1;
            utf8_state = 0;
         end else begin
            case (utf8_state)
               3'd2, 3'd4, 3'd5: utf8_state = 3'd1;
               3'd3, 3'd6, 3'd7: utf8_state = 3'd2;
               default: utf8_state = 3'd0;
            endcase
         end
      end else if (b >= 8'h80) begin
         if (b >= 8'hC2 && b <= 8'hDF) utf8_state = 3'd1;
         else if (b == 8'hE0) utf8_state = 3'd4;
         else if (b == 8'hED) utf8_state = 3'd5;
         else if (b >= 8'hE1 && b <= 8'hEF) utf8_state = 3'd2;
         else if (b == 8'hF0) utf8_state = 3'd6;
         else if (b >= 8'hF1 && b <= 8'hF3) utf8_state = 3'd3;
         else if (b == 8'hF4) utf8_state = 3'd7;
         else utf8_bad = 1;
      end
   endfunction

   function automatic void after_zero(logic [2:0] aligned, logic [2:0] pad);
      phase = (((pos + 1) % 4) == 0) ? aligned : pad;
   endfunction

   function automatic void close_address();
      int r;
      int unsigned len;
      bit found;
      found = 0;
      addr_end = pos;
      if (utf8_state != 0) begin
         utf8_bad = 1;
         utf8_state = 0;
      end
      for (r = 0; r < 3 && !found; r++) begin
         len = rule_attr[6*r +: 5];
         if (len != 0 && len <= 16 && still_match[r] && len <= pos) found = 1;
      end
      if (!found) begin
         set_reject(RSN_NO_RULE);
         return;
      end
      r = r - 1;
      still_match = 3'b001 << r;
      if (bypass_en && rule_attr[6*r+5] && digit_seen[r]) begin
         set_reject(RSN_DIGIT);
         return;
      end
      if (!rule_attr[6*r+5]) begin
         phase = PH_IDLE;
         return;
      end
      tag_bits[2] = 1'b1;
      after_zero(PH_TAG, PH_PAD1);
   endfunction

   function automatic void address_byte(logic [7:0] b);
      int unsigned len;
      logic [63:0] w;
      if (pos == 0 && b != CH_SLASH) begin
         set_reject(RSN_NO_SLASH);
         return;
      end
      if (b == 0) begin
         close_address();
         return;
      end
      for (int r = 0; r < 3; r++) begin
         len = rule_attr[6*r +: 5];
         if (pos < len && pos < 16) begin
            w = prefix_reg[r][pos / 8];
            if (w[(pos % 8) * 8 +: 8] != b) still_match[r] = 1'b0;
         end
         if (pos == len && b >= CH_ZERO && b <= CH_NINE) digit_seen[r] = 1'b1;
      end
      step_utf8(b);
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      case (phase)
         PH_ADDR: address_byte(b);
         PH_PAD1: after_zero(PH_TAG, PH_PAD1);
         PH_TAG: begin
            if (!tag_bits[0]) begin
               if (b != CH_COMMA) set_reject(RSN_NO_COMMA);
               else tag_bits[0] = 1'b1;
            end else if (!tag_bits[1]) begin
               if (b != CH_I) set_reject(RSN_NOT_INT);
               else tag_bits[1] = 1'b1;
            end else if (b == 0) begin
               after_zero(PH_ARG, PH_PAD2);
            end
         end
         PH_PAD2: after_zero(PH_ARG, PH_PAD2);
         PH_ARG: begin
            arg_shift = {arg_shift[23:0], b};
            arg_count++;
            if (arg_count >= 4) phase = PH_IDLE;
         end
         default: ;
      endcase
   endfunction

   // advances the parser by one byte; returns 1 with a verdict on the last byte
   function automatic bit classify_byte(logic [7:0] b, logic last, output verdict_type v);
      logic [3:0] why;
      v = '0;
      if (pos >= MAX_BYTES) begin
         set_reject(RSN_OVERSIZE);
      end else begin
         if (latched_reason == RSN_OK) parse_byte(b);
         pos++;
      end
      if (!last) return 0;
      if (latched_reason != RSN_OK) why = latched_reason;
      else begin
         case (phase)
            PH_ADDR: why = RSN_NO_TERM;
            PH_PAD1: why = RSN_NO_COMMA;
            PH_TAG:  why = !tag_bits[0] ? RSN_NO_COMMA :
                           !tag_bits[1] ? RSN_NOT_INT : RSN_TAG_OPEN;
            PH_PAD2, PH_ARG: why = RSN_ARG_SHORT;
            default: why = utf8_bad ? RSN_BAD_UTF8 : RSN_OK;
         endcase
      end
      v.accepted = (why == RSN_OK);
      v.reject_reason = why;
      if (why == RSN_OK) begin
         v.rule_index = still_match[0] ? 2'd0 : still_match[1] ? 2'd1 : 2'd2;
         v.keyed_by_channel = tag_bits[2];
         v.address_length = addr_end[9:0];
         if (tag_bits[2]) v.channel_id = arg_shift;
      end
      clear_packet_state();
      return 1;
   endfunction

   // input side: predict on every accepted word, plus the cycle limit
   always @(posedge clock) begin
      verdict_type v;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         if (classify_byte(req_tdata, req_tlast, v)) verdict_q.insert(verdict_q.size(), v);
         bytes_taken++;
      end
   end

   // result side
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(verdict_type)-1:0];
         verdicts_seen++;
         if (got.accepted) accepts_seen++;
         if (verdict_q.size() == 0) begin
            $error("verdict with none expected: %h", got);
            errors++;
         end else begin
            want = verdict_q[0];
            verdict_q.delete(0);
            if (got.accepted !== want.accepted) begin
               $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
               errors++;
            end
            if (got.reject_reason !== want.reject_reason) begin
               $error("reject_reason: expected %0d actual %0d",
                      want.reject_reason, got.reject_reason);
               errors++;
            end
            if (got.rule_index !== want.rule_index) begin
               $error("rule_index: expected %0d actual %0d", want.rule_index, got.rule_index);
               errors++;
            end
            if (got.keyed_by_channel !== want.keyed_by_channel) begin
               $error("keyed_by_channel: expected %0d actual %0d",
                      want.keyed_by_channel, got.keyed_by_channel);
               errors++;
            end
            if (got.address_length !== want.address_length) begin
               $error("address_length: expected %0d actual %0d",
                      want.address_length, got.address_length);
               errors++;
            end
            if (got.channel_id !== want.channel_id) begin
               $error("channel_id: expected %h actual %h", want.channel_id, got.channel_id);
               errors++;
            end
         end
      end
   end

   // output ready, with the long hold-off counted here
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_word(logic [7:0] b, logic last);
      int unsigned mark;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = last;
      mark = bytes_taken;
      do @(negedge clock); while (bytes_taken == mark);
      req_tvalid = 1'b0;
   endtask

   task automatic send_packet(byte_q_t pkt);
      foreach (pkt[k]) send_word(pkt[k], k == pkt.size() - 1);
      packets_sent++;
   endtask

   task automatic drain();
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      csr_wen = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx < CSR_ATTR) prefix_reg[idx / 2][idx % 2] = val;
      else if (idx == CSR_ATTR) rule_attr = val[17:0];
      else bypass_en = val[0];
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   task automatic set_prefix(int r, string s);
      logic [127:0] p;
      p = '0;
      for (int k = 0; k < s.len() && k < 16; k++) p[8*k +: 8] = s[k];
      csr_write(CSR_PREFIX_BASE + 3'(2*r), p[63:0]);
      csr_write(CSR_PREFIX_BASE + 3'(2*r + 1), p[127:64]);
   endtask

   function automatic logic [17:0] rule_word(int l0, bit c0, int l1, bit c1, int l2, bit c2);
      return {c2, 5'(l2), c1, 5'(l1), c0, 5'(l0)};
   endfunction

   function automatic byte_q_t str_bytes(string s);
      byte_q_t q;
      for (int k = 0; k < s.len(); k++) q.insert(q.size(), s[k]);
      return q;
   endfunction

   function automatic void pad4(ref byte_q_t q);
      while (q.size() % 4 != 0) q.insert(q.size(), 8'h00);
   endfunction

   // address, terminator, and optionally a ",i" tag with a 32-bit argument
   function automatic byte_q_t osc_msg(byte_q_t addr, bit with_arg, logic [31:0] chan);
      byte_q_t q;
      q = addr;
      q.insert(q.size(), 8'h00);
      pad4(q);
      if (with_arg) begin
         q.insert(q.size(), CH_COMMA);
         q.insert(q.size(), CH_I);
         q.insert(q.size(), 8'h00);
         pad4(q);
         for (int k = 3; k >= 0; k--) q.insert(q.size(), chan[8*k +: 8]);
      end
      return q;
   endfunction

   task automatic standard_rules();
      set_prefix(0, "/ch/");
      set_prefix(1, "/synth/osc/level");
      set_prefix(2, "/m");
      csr_write(CSR_ATTR, 64'(rule_word(4, 1, 16, 0, 2, 1)));
      csr_write(CSR_BYPASS, 64'd1);
   endtask

   task automatic test_directed();
      byte_q_t q;
      standard_rules();
      send_packet(str_bytes("ch"));                                       // no slash
      send_packet(str_bytes("/ch/5"));                                    // no terminator
      send_packet(osc_msg(str_bytes("/zz"), 0, 0));                       // no rule
      send_packet(osc_msg(str_bytes("/ch/7"), 1, 32'd7));                 // digit bypass
      q = osc_msg(str_bytes("/ch/a"), 0, 0);
      q.insert(q.size(), 8'h2E);
      send_packet(q);                                                     // no comma
      q = osc_msg(str_bytes("/ch/a"), 0, 0);
      q.insert(q.size(), CH_COMMA);
      q.insert(q.size(), 8'h66);
      send_packet(q);                                                     // not int
      q = osc_msg(str_bytes("/ch/a"), 0, 0);
      q.insert(q.size(), CH_COMMA);
      q.insert(q.size(), CH_I);
      q.insert(q.size(), CH_I);
      send_packet(q);                                                     // tag open
      q = osc_msg(str_bytes("/ch/a"), 1, 32'h12345678);
      void'(q.pop_back());
      send_packet(q);                                                     // arg short
      send_packet(osc_msg({str_bytes("/ma"), 8'hC0, 8'hAF}, 1, 1));       // overlong
      send_packet(osc_msg({str_bytes("/ma"), 8'hED, 8'hA0, 8'h80}, 1, 1)); // surrogate
      send_packet(osc_msg({str_bytes("/ma"), 8'hF4, 8'h90, 8'h80, 8'h80}, 1, 1));
      send_packet(osc_msg({str_bytes("/ma"), 8'hF5}, 1, 1));
      send_packet(osc_msg({str_bytes("/ma"), 8'hE2, 8'h82}, 1, 1));       // cut by terminator
      send_packet(osc_msg({str_bytes("/ma"), 8'hF0, 8'h9F, 8'h98, 8'h80,
                           8'hC3, 8'hA9}, 1, 32'hFFFFFFFF));
      send_packet(osc_msg(str_bytes("/synth/osc/level"), 0, 0));          // plain accept
      send_packet(osc_msg(str_bytes("/ch/x"), 1, 32'h80000000));
      send_packet(osc_msg(str_bytes("/ch/x"), 1, 32'h7FFFFFFF));
      send_packet(osc_msg(str_bytes("/mix"), 1, 32'h00000000));
      send_packet(str_bytes("/"));
      drain();
      // oversize with an otherwise valid start
      q = osc_msg(str_bytes("/ch/y"), 1, 32'd3);
      while (q.size() < MAX_BYTES + 3) q.insert(q.size(), 8'($urandom));
      send_packet(q);
      drain();
   endtask

   task automatic test_rule_settings();
      // nothing enabled, then every bit set (lengths too long to be usable)
      csr_write(CSR_ATTR, 64'd0);
      send_packet(osc_msg(str_bytes("/ch/x"), 1, 5));
      drain();
      for (int r = 0; r < 3; r++) begin
         csr_write(CSR_PREFIX_BASE + 3'(2*r), '1);
         csr_write(CSR_PREFIX_BASE + 3'(2*r + 1), '1);
      end
      csr_write(CSR_ATTR, 64'h3FFFF);
      csr_write(CSR_BYPASS, 64'd0);
      send_packet(osc_msg({8'h2F, 8'hFF, 8'hFF}, 1, 5));
      drain();
      // overlapping prefixes: first enabled match wins, bypass off lets digits in
      set_prefix(0, "/a/b");
      set_prefix(1, "/a");
      set_prefix(2, "/a/b/c");
      csr_write(CSR_ATTR, 64'(rule_word(0, 1, 2, 1, 6, 0)));
      send_packet(osc_msg(str_bytes("/a/b/c"), 0, 0));
      send_packet(osc_msg(str_bytes("/a9"), 1, 32'hA5A5_5A5A));
      send_packet(osc_msg(str_bytes("/a"), 1, 9));
      drain();
      csr_write(CSR_ATTR, 64'(rule_word(4, 0, 17, 1, 1, 1)));
      csr_write(CSR_BYPASS, 64'd1);
      send_packet(osc_msg(str_bytes("/a/b1"), 0, 0));
      send_packet(osc_msg(str_bytes("/q5"), 1, 2));
      send_packet(osc_msg(str_bytes("/"), 1, 2));
      drain();
   endtask

   function automatic byte_q_t random_packet();
      byte_q_t q;
      int r;
      int len;
      q = {};
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 10)) q.insert(q.size(), 8'($urandom));
         return q;
      end
      r = $urandom_range(2);
      len = rule_attr[6*r +: 5];
      if (len > 16) len = 16;
      for (int k = 0; k < len; k++)
         q.insert(q.size(), prefix_reg[r][k / 8][(k % 8) * 8 +: 8]);
      if (q.size() == 0) q.insert(q.size(), CH_SLASH);
      if ($urandom_range(3) == 0) q.insert(q.size(), CH_ZERO + 8'($urandom_range(9)));
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(9))
            0: begin
               q.insert(q.size(), 8'hC3);
               q.insert(q.size(), 8'hA9);
            end
            1: q.insert(q.size(), 8'($urandom));
            default: q.insert(q.size(), 8'h61 + 8'($urandom_range(25)));
         endcase
      end
      q = osc_msg(q, rule_attr[6*r+5] || $urandom_range(3) == 0, $urandom);
      if ($urandom_range(99) < 15) q[$urandom_range(q.size() - 1)] = 8'($urandom);
      if ($urandom_range(99) < 10) begin
         len = $urandom_range(1, q.size());
         while (q.size() > len) void'(q.pop_back());
      end
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 4)) q.insert(q.size(), 8'($urandom));
      return q;
   endfunction

   task automatic test_random(int unsigned n_bytes);
      int unsigned stop_at;
      stop_at = bytes_taken + n_bytes;
      while (bytes_taken < stop_at) send_packet(random_packet());
      drain();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (40) send_packet(str_bytes("/"));
      repeat (12) send_packet(osc_msg(str_bytes("/ch/k"), 1, $urandom));
      drain();
   endtask

   initial begin
      prefix_reg = '{default: '0};
      rule_attr = '0;
      bypass_en = 1'b0;
      clear_packet_state();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_rule_settings();
      standard_rules();
      send_idle = 14;
      recv_idle = 83;
      test_random(150);
      send_idle = 83;
      recv_idle = 14;
      test_random(150);
      send_idle = 0;
      recv_idle = 0;
      test_backpressure();
      test_random(150);
      repeat (20) @(negedge clock);
      $display("covered %0d packets (%0d bytes) over several rule settings,", packets_sent,
               bytes_taken);
      $display("%0d verdicts checked, %0d accepted", verdicts_seen, accepts_seen);
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
design/omcc_pkg.sv
design/osc_message_coalesce_classifier_top.sv
tb/tb_osc_message_coalesce_classifier_top.sv
